/* hw/rtl/lpu_pkg.sv */
// ----------------------------------------------------------------------------
// lpu_pkg
// Shared types, field layout, register codes and the tone-map knot table for
// the latent preview upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lpu_pkg;

    // Default sizes of the latent store and the scale range
    localparam int DEF_MAX_LATENT_WIDTH  = 128;
    localparam int DEF_MAX_LATENT_HEIGHT = 128;
    localparam int DEF_MAX_SCALE         = 16;

    // Field widths
    localparam int CELL_W      = 7;
    localparam int PIX_W       = 11;
    localparam int CHAN_W      = 16;
    localparam int NUM_CHAN    = 3;
    localparam int CELL_DATA_W = NUM_CHAN * CHAN_W;

    // Stream data widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = CELL_DATA_W;

    // Input tdata layout, lowest field first
    localparam int OFS_CELL_COL = 0;
    localparam int OFS_CELL_ROW = OFS_CELL_COL + CELL_W;
    localparam int OFS_PIX_COL  = OFS_CELL_ROW + CELL_W;
    localparam int OFS_PIX_ROW  = OFS_PIX_COL + PIX_W;
    localparam int OFS_CHAN     = OFS_PIX_ROW + PIX_W;

    // Item kinds carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DIM_W      = 8;
    localparam int SCALE_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_LATENT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATENT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

    localparam logic [DIM_W-1:0]   RST_LATENT_WIDTH  = 8'd64;
    localparam logic [DIM_W-1:0]   RST_LATENT_HEIGHT = 8'd64;
    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR  = 5'd8;

    // Queue depths between front, back and the result port
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 8;

    // Tone map: 17 knots, one every 2048 LSB of the Q4.12 magnitude
    localparam int KNOT_W  = 5;
    localparam int FRAC_W  = 11;
    localparam int INTERP_W = CHAN_W + FRAC_W;
    localparam logic [CHAN_W:0]     HALF_ONE   = 17'h08000;
    localparam logic [INTERP_W-1:0] ROUND_HALF = INTERP_W'(1) << (FRAC_W - 1);

    typedef struct packed {
        logic [DIM_W-1:0]   latent_width;
        logic [DIM_W-1:0]   latent_height;
        logic [SCALE_W-1:0] scale_factor;
    } lpu_cfg_t;

    // One classified item: coordinates are cell coordinates for a load and
    // pixel coordinates for a pixel request
    typedef struct packed {
        logic                   is_pixel;
        logic [PIX_W-1:0]       coord_x;
        logic [PIX_W-1:0]       coord_y;
        logic [CELL_DATA_W-1:0] data;
    } lpu_item_t;

    localparam int ITEM_W = 1 + 2 * PIX_W + CELL_DATA_W;

    // Half-scale tanh(0.4 k) in Q0.15; past the last knot it stays at one
    function automatic logic [CHAN_W-1:0] tanh_half(input logic [KNOT_W-1:0] knot);
        logic [CHAN_W-1:0] val;
        case (knot)
            5'd0:    val = 16'd0;
            5'd1:    val = 16'd12450;
            5'd2:    val = 16'd21759;
            5'd3:    val = 16'd27317;
            5'd4:    val = 16'd30201;
            5'd5:    val = 16'd31589;
            5'd6:    val = 16'd32233;
            5'd7:    val = 16'd32527;
            5'd8:    val = 16'd32659;
            5'd9:    val = 16'd32719;
            5'd10:   val = 16'd32746;
            5'd11:   val = 16'd32758;
            5'd12:   val = 16'd32764;
            5'd13:   val = 16'd32766;
            5'd14:   val = 16'd32767;
            default: val = 16'd32768;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpu_fifo.sv */
// ----------------------------------------------------------------------------
// lpu_fifo
// Small register queue with valid/ready on both sides; used between the front
// and back parts and in front of the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CNTW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[head_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers with wrap at the depth
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop) begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (push) begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        cnt_next = cnt_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store the beat
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpu_front.sv */
// ----------------------------------------------------------------------------
// lpu_front
// Input stage: takes stream beats, unpacks the fields, drops loads outside the
// store and hands classified items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpu_front #(
    parameter int MAX_LATENT_WIDTH  = lpu_pkg::DEF_MAX_LATENT_WIDTH,
    parameter int MAX_LATENT_HEIGHT = lpu_pkg::DEF_MAX_LATENT_HEIGHT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lpu_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output lpu_pkg::lpu_item_t                 q_item
);

    import lpu_pkg::*;

    logic              valid_reg, valid_next;
    lpu_item_t         item_reg, item_next;
    logic              accept, keep, in_window, is_pixel;
    logic [CELL_W-1:0] cell_col, cell_row;

    assign cell_col = s_tdata[OFS_CELL_COL +: CELL_W];
    assign cell_row = s_tdata[OFS_CELL_ROW +: CELL_W];
    assign is_pixel = (s_tuser == OP_PIXEL);

    // A load beyond the store is dropped here
    assign in_window = (int'(cell_col) < MAX_LATENT_WIDTH) &&
                       (int'(cell_row) < MAX_LATENT_HEIGHT);
    assign keep      = is_pixel || in_window;

    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    // Classify the beat
    always_comb begin
        item_next.is_pixel = is_pixel;
        item_next.data     = s_tdata[OFS_CHAN +: CELL_DATA_W];
        if (is_pixel) begin
            item_next.coord_x = s_tdata[OFS_PIX_COL +: PIX_W];
            item_next.coord_y = s_tdata[OFS_PIX_ROW +: PIX_W];
        end else begin
            item_next.coord_x = PIX_W'(cell_col);
            item_next.coord_y = PIX_W'(cell_row);
        end
    end

    // Hold the item until the queue takes it
    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = keep;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpu_back.sv */
// ----------------------------------------------------------------------------
// lpu_back
// Execution pipeline: coordinate scaling by reciprocal multiply, clamp, latent
// store access, piecewise-linear tanh tone map and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpu_back #(
    parameter int MAX_LATENT_WIDTH  = lpu_pkg::DEF_MAX_LATENT_WIDTH,
    parameter int MAX_LATENT_HEIGHT = lpu_pkg::DEF_MAX_LATENT_HEIGHT,
    parameter int MAX_SCALE         = lpu_pkg::DEF_MAX_SCALE
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lpu_pkg::lpu_cfg_t             cfg,
    input  wire logic                          q_valid,
    input  wire lpu_pkg::lpu_item_t            q_item,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lpu_pkg::M_TDATA_W-1:0] m_tdata
);

    import lpu_pkg::*;

    // Reciprocal multiply: q = (p * ceil(2^RSH / s)) >> RSH is exact for
    // every pixel coordinate and every scale up to MAX_SCALE
    localparam int SW     = $clog2(MAX_SCALE + 1);
    localparam int RSH    = PIX_W + SW;
    localparam int RW     = RSH + 1;
    localparam int PROD_W = PIX_W + RW;
    localparam int WB     = $clog2(MAX_LATENT_WIDTH + 1);
    localparam int HB     = $clog2(MAX_LATENT_HEIGHT + 1);
    localparam int CB     = (MAX_LATENT_WIDTH > 1) ? $clog2(MAX_LATENT_WIDTH) : 1;
    localparam int RB     = (MAX_LATENT_HEIGHT > 1) ? $clog2(MAX_LATENT_HEIGHT) : 1;
    localparam int AW     = CB + RB;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

    // ------------------------------------------------------------------
    // Effective configuration
    // ------------------------------------------------------------------
    logic [SW-1:0] scale_eff;
    logic [WB-1:0] width_eff, width_lim;
    logic [HB-1:0] height_eff, height_lim;

    always_comb begin
        if (cfg.scale_factor == '0) begin
            scale_eff = SW'(1);
        end else if (int'(cfg.scale_factor) > MAX_SCALE) begin
            scale_eff = SW'(MAX_SCALE);
        end else begin
            scale_eff = SW'(cfg.scale_factor);
        end
        if (cfg.latent_width == '0) begin
            width_eff = WB'(1);
        end else if (int'(cfg.latent_width) > MAX_LATENT_WIDTH) begin
            width_eff = WB'(MAX_LATENT_WIDTH);
        end else begin
            width_eff = WB'(cfg.latent_width);
        end
        if (cfg.latent_height == '0) begin
            height_eff = HB'(1);
        end else if (int'(cfg.latent_height) > MAX_LATENT_HEIGHT) begin
            height_eff = HB'(MAX_LATENT_HEIGHT);
        end else begin
            height_eff = HB'(cfg.latent_height);
        end
        width_lim  = width_eff - WB'(1);
        height_lim = height_eff - HB'(1);
    end

    // Reciprocal table, one entry per scale value
    logic [RW-1:0] recip_tab [MAX_SCALE + 1];

    for (genvar gi = 0; gi <= MAX_SCALE; gi++) begin : g_recip
        if (gi == 0) begin : g_zero
            assign recip_tab[gi] = '0;
        end else begin : g_val
            localparam longint RecipVal = ((longint'(1) << RSH) + gi - 1) / gi;
            assign recip_tab[gi] = RW'(RecipVal);
        end
    end

    logic [RW-1:0] recip;
    assign recip = recip_tab[scale_eff];

    // ------------------------------------------------------------------
    // Issue: a pixel needs a free slot in the result queue
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] credit_reg, credit_next;
    logic             issue_pix, issue, m_pop;

    assign issue_pix = q_valid && q_item.is_pixel && (credit_reg < CNT_W'(OUT_DEPTH));
    assign issue     = issue_pix || (q_valid && !q_item.is_pixel);
    assign q_pop     = issue;
    assign m_pop     = m_tvalid && m_tready;

    assign credit_next = credit_reg + CNT_W'(issue_pix) - CNT_W'(m_pop);

    // ------------------------------------------------------------------
    // Stage 1: scale the coordinates
    // ------------------------------------------------------------------
    logic                   st1_valid_reg;
    logic                   st1_pixel_reg;
    logic [PROD_W-1:0]      st1_x_reg, st1_y_reg;
    logic [CELL_DATA_W-1:0] st1_data_reg;
    logic [PROD_W-1:0]      prod_x, prod_y;

    assign prod_x = PROD_W'(q_item.coord_x) * PROD_W'(recip);
    assign prod_y = PROD_W'(q_item.coord_y) * PROD_W'(recip);

    always_ff @(posedge aclk) begin
        if (issue) begin
            st1_pixel_reg <= q_item.is_pixel;
            st1_data_reg  <= q_item.data;
            if (q_item.is_pixel) begin
                st1_x_reg <= prod_x;
                st1_y_reg <= prod_y;
            end else begin
                st1_x_reg <= PROD_W'(q_item.coord_x);
                st1_y_reg <= PROD_W'(q_item.coord_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp, then write or read the latent store
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] lx, ly, lx_c, ly_c;
    logic [AW-1:0]    addr;

    always_comb begin
        if (st1_pixel_reg) begin
            lx = st1_x_reg[RSH +: PIX_W];
            ly = st1_y_reg[RSH +: PIX_W];
        end else begin
            lx = st1_x_reg[PIX_W-1:0];
            ly = st1_y_reg[PIX_W-1:0];
        end
        lx_c = lx;
        ly_c = ly;
        if (st1_pixel_reg && (lx > PIX_W'(width_lim))) begin
            lx_c = PIX_W'(width_lim);
        end
        if (st1_pixel_reg && (ly > PIX_W'(height_lim))) begin
            ly_c = PIX_W'(height_lim);
        end
        addr = {ly_c[RB-1:0], lx_c[CB-1:0]};
    end

    logic [CELL_DATA_W-1:0] store_mem [MEM_DEPTH];
    logic [CELL_DATA_W-1:0] rd_reg;
    logic                   st2_valid_reg;

    always_ff @(posedge aclk) begin
        if (st1_valid_reg && !st1_pixel_reg) begin
            store_mem[addr] <= st1_data_reg;
        end
        if (st1_valid_reg && st1_pixel_reg) begin
            rd_reg <= store_mem[addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 and 4: tone map each channel
    // ------------------------------------------------------------------
    logic                   st3_valid_reg;
    logic [CELL_DATA_W-1:0] out_word;
    logic                   out_ready;

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        logic [CHAN_W-1:0]   bits;
        logic [CHAN_W:0]     mag_w;
        logic [CHAN_W-1:0]   mag;
        logic [KNOT_W-1:0]   knot;
        logic [FRAC_W-1:0]   frac;
        logic [CHAN_W-1:0]   lo, hi, diff;
        logic                neg_reg, sat_reg;
        logic [CHAN_W-1:0]   base_reg;
        logic [INTERP_W-1:0] prod_reg;
        logic [INTERP_W-1:0] rounded;
        logic [CHAN_W:0]     half_val;
        logic [CHAN_W+1:0]   pos_sum;
        logic [CHAN_W-1:0]   chan_out;

        // Split the magnitude into knot and fraction
        assign bits  = rd_reg[c*CHAN_W +: CHAN_W];
        assign mag_w = bits[CHAN_W-1] ? ({1'b1, {CHAN_W{1'b0}}} - {1'b0, bits})
                                      : {1'b0, bits};
        assign mag   = mag_w[CHAN_W-1:0];
        assign knot  = mag[FRAC_W +: KNOT_W];
        assign frac  = mag[FRAC_W-1:0];
        assign lo    = tanh_half(knot);
        assign hi    = tanh_half(knot + KNOT_W'(1));
        assign diff  = hi - lo;

        always_ff @(posedge aclk) begin
            neg_reg  <= bits[CHAN_W-1];
            sat_reg  <= knot[KNOT_W-1];
            base_reg <= lo;
            prod_reg <= INTERP_W'(diff) * INTERP_W'(frac);
        end

        // Interpolate, then fold around one half
        assign rounded  = prod_reg + ROUND_HALF;
        assign half_val = sat_reg ? HALF_ONE
                                  : ({1'b0, base_reg} + {1'b0, rounded[FRAC_W +: CHAN_W]});
        assign pos_sum  = {1'b0, half_val} + {1'b0, HALF_ONE};

        always_comb begin
            if (neg_reg) begin
                chan_out = (half_val >= HALF_ONE) ? '0 : CHAN_W'(HALF_ONE - half_val);
            end else if (pos_sum[CHAN_W+1:CHAN_W] != '0) begin
                chan_out = '1;
            end else begin
                chan_out = pos_sum[CHAN_W-1:0];
            end
        end

        assign out_word[c*CHAN_W +: CHAN_W] = chan_out;
    end

    // Valid chain and credit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            credit_reg    <= '0;
        end else begin
            st1_valid_reg <= issue;
            st2_valid_reg <= st1_valid_reg && st1_pixel_reg;
            st3_valid_reg <= st2_valid_reg;
            credit_reg    <= credit_next;
        end
    end

    // Result queue; the credit count keeps it from overflowing
    lpu_fifo #(
        .WIDTH (M_TDATA_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (st3_valid_reg && out_ready),
        .wr_ready (out_ready),
        .wr_data  (out_word),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/latent_preview_upscaler.sv */
// ----------------------------------------------------------------------------
// latent_preview_upscaler
// Latent-to-RGB preview: nearest-neighbor upscale of a latent store with a
// tanh tone map per channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: s_tuser selects the item kind (0 load a latent cell, 1 ask
//   for one pixel). A load writes three signed Q4.12 channels at a cell; a
//   pixel beat names a pixel coordinate, which is divided by scale_factor and
//   clamped to the last latent column and row.
//   m_* channel: one beat per pixel request, three unsigned Q0.16 channels.
//   Loads produce no beat. Results leave in request order.
//   cfg_*: write latent_width, latent_height and scale_factor while idle.
//   Throughput is one item per cycle when no pixel is held for a result slot.
//   A pixel beat is accepted into the input register, then passes through
//   the issue queue, the reciprocal multiply, store read and tone-map
//   multiply registers and the result queue before m_tvalid rises.
//   When the receiver stalls, at most eight pixels are held between issue
//   and the port (pipeline plus eight-beat result queue). The next pixel
//   waits at the head of the issue queue and holds back every item behind
//   it; s_tready drops once the issue queue and input register are full.
//   Reset clears all queues and restores the register defaults (64, 64, 8).
//   The latent store is not cleared; a cell must be loaded before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module latent_preview_upscaler #(
    parameter int MAX_LATENT_WIDTH  = lpu_pkg::DEF_MAX_LATENT_WIDTH,
    parameter int MAX_LATENT_HEIGHT = lpu_pkg::DEF_MAX_LATENT_HEIGHT,
    parameter int MAX_SCALE         = lpu_pkg::DEF_MAX_SCALE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cell_column[6:0], cell_row[13:7], pixel_column[24:14], pixel_row[35:25],
    // red_in[51:36], green_in[67:52], blue_in[83:68], zero fill[87:84]
    input  wire logic [lpu_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[0]
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    output logic      [lpu_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [lpu_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [lpu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import lpu_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    lpu_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                REG_LATENT_WIDTH:  cfg_next.latent_width  = cfg_wdata[DIM_W-1:0];
                REG_LATENT_HEIGHT: cfg_next.latent_height = cfg_wdata[DIM_W-1:0];
                REG_SCALE_FACTOR:  cfg_next.scale_factor  = cfg_wdata[SCALE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.latent_width  <= RST_LATENT_WIDTH;
            cfg_reg.latent_height <= RST_LATENT_HEIGHT;
            cfg_reg.scale_factor  <= RST_SCALE_FACTOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front, issue queue, back
    // ------------------------------------------------------------------
    lpu_item_t         f_item, q_item;
    logic [ITEM_W-1:0] q_data;
    logic              f_valid, f_ready, q_valid, q_pop;

    lpu_front #(
        .MAX_LATENT_WIDTH  (MAX_LATENT_WIDTH),
        .MAX_LATENT_HEIGHT (MAX_LATENT_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    lpu_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_issue_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_pop),
        .rd_data  (q_data)
    );

    assign q_item = q_data;

    lpu_back #(
        .MAX_LATENT_WIDTH  (MAX_LATENT_WIDTH),
        .MAX_LATENT_HEIGHT (MAX_LATENT_HEIGHT),
        .MAX_SCALE         (MAX_SCALE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/lpu_checker.sv */
// ----------------------------------------------------------------------------
// lpu_checker
// Port-level checks on the upscaler: result beat stability, reset behavior
// and the minimum pipeline depth after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lpu_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lpu_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat stays and keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the result queue and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("queues not empty after reset");

    // No result can reach the port straight after a reset
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3))
        else $error("result appeared too soon after reset");

endmodule

bind latent_preview_upscaler lpu_checker u_lpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* test/latent_preview_checker.sv */
// ----------------------------------------------------------------------------
// latent_preview_checker
// Watches the item, result and register ports of the latent preview
// upscaler. It keeps its own latent store and register copies, works out the
// tone-mapped pixel for every accepted pixel request, and compares each
// result beat against the oldest pixel still owed.
// ----------------------------------------------------------------------------

module latent_preview_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lpu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lpu_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [lpu_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [lpu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              pending,
    output int                              pixels_checked,
    output int                              loads_seen
);
    import lpu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Packed in result-beat order: red in the lowest bits
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    logic [CELL_DATA_W-1:0] latent_cells [DEF_MAX_LATENT_HEIGHT][DEF_MAX_LATENT_WIDTH];
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic [SCALE_W-1:0]     scale_reg;
    rgb_t                   owed_pixels [$];

    // Half-scale tanh(0.4 k) in Q0.15 at each knot
    function automatic int unsigned knot_level(input int unsigned k);
        int unsigned lvl;
        case (k)
            0:       lvl = 0;
            1:       lvl = 12450;
            2:       lvl = 21759;
            3:       lvl = 27317;
            4:       lvl = 30201;
            5:       lvl = 31589;
            6:       lvl = 32233;
            7:       lvl = 32527;
            8:       lvl = 32659;
            9:       lvl = 32719;
            10:      lvl = 32746;
            11:      lvl = 32758;
            12:      lvl = 32764;
            13:      lvl = 32766;
            14:      lvl = 32767;
            default: lvl = 32768;
        endcase
        return lvl;
    endfunction

    // Map one signed Q4.12 channel to unsigned Q0.16 through the tanh curve
    function automatic logic [CHAN_W-1:0] tone_curve(input logic [CHAN_W-1:0] v);
        int unsigned mag;
        int unsigned k;
        int unsigned frac;
        int unsigned half;
        int unsigned lo;
        int unsigned hi;
        mag  = v[CHAN_W-1] ? 32'h10000 - 32'(v) : 32'(v);
        k    = mag >> 11;
        frac = mag & 32'd2047;
        if (k >= 16) begin
            half = knot_level(16);
        end else begin
            lo   = knot_level(k);
            hi   = knot_level(k + 1);
            half = lo + (((hi - lo) * frac + 32'd1024) >> 11);
        end
        if (v[CHAN_W-1]) begin
            return (half >= 32768) ? '0 : CHAN_W'(32768 - half);
        end
        return (32768 + half > 65535) ? '1 : CHAN_W'(32768 + half);
    endfunction

    // Zero acts as one, anything past the maximum acts as the maximum
    function automatic int clamp_size(input int v, input int limit);
        if (v == 0) begin
            return 1;
        end
        return (v > limit) ? limit : v;
    endfunction

    always @(posedge aclk) begin : watch
        rgb_t                   want;
        rgb_t                   got;
        int                     sc;
        int                     wc;
        int                     hc;
        int                     col;
        int                     row;
        logic [CELL_DATA_W-1:0] texel;

        if (!aresetn) begin
            width_reg  = RST_LATENT_WIDTH;
            height_reg = RST_LATENT_HEIGHT;
            scale_reg  = RST_SCALE_FACTOR;
            owed_pixels.delete();
            fail_count     = 0;
            pixels_checked = 0;
            loads_seen     = 0;
        end else begin
            // Compare a result beat against the oldest owed pixel
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (owed_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result beat %h with no pixel request waiting",
                                 m_tdata);
                    end
                end else begin
                    want = owed_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("pixel %0d: expected r/g/b %h %h %h, got %h %h %h",
                                     pixels_checked, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                    pixels_checked++;
                end
            end

            // Predict a pixel request or apply a load
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_PIXEL) begin
                    sc  = clamp_size(int'(scale_reg), DEF_MAX_SCALE);
                    wc  = clamp_size(int'(width_reg), DEF_MAX_LATENT_WIDTH);
                    hc  = clamp_size(int'(height_reg), DEF_MAX_LATENT_HEIGHT);
                    col = int'(s_tdata[OFS_PIX_COL +: PIX_W]) / sc;
                    row = int'(s_tdata[OFS_PIX_ROW +: PIX_W]) / sc;
                    if (col > wc - 1) begin
                        col = wc - 1;
                    end
                    if (row > hc - 1) begin
                        row = hc - 1;
                    end
                    texel      = latent_cells[row][col];
                    want.red   = tone_curve(texel[0 +: CHAN_W]);
                    want.green = tone_curve(texel[CHAN_W +: CHAN_W]);
                    want.blue  = tone_curve(texel[2*CHAN_W +: CHAN_W]);
                    owed_pixels.push_back(want);
                end else begin
                    col = int'(s_tdata[OFS_CELL_COL +: CELL_W]);
                    row = int'(s_tdata[OFS_CELL_ROW +: CELL_W]);
                    latent_cells[row][col] = s_tdata[OFS_CHAN +: CELL_DATA_W];
                    loads_seen++;
                end
            end

            // Track register writes
            if (cfg_we) begin
                case (cfg_idx)
                    REG_LATENT_WIDTH:  width_reg  = cfg_wdata;
                    REG_LATENT_HEIGHT: height_reg = cfg_wdata;
                    REG_SCALE_FACTOR:  scale_reg  = cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = owed_pixels.size();
    end

endmodule

/* test/tb_latent_preview_upscaler.sv */
// ----------------------------------------------------------------------------
// tb_latent_preview_upscaler
// Drives load and pixel beats into the latent preview upscaler across a set
// of register settings, with random gaps on both streams, a long result
// stall, and directed tone-map extremes. Pixel requests only ever land on
// cells that have been loaded. The checker predicts and compares; this top
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------

module tb_latent_preview_upscaler;
    import lpu_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 80;
    localparam int GAP_MAX      = 8;
    localparam int STRESS_PHASE = 6;
    localparam int STALL_HOLD   = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 500000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // cell_column, cell_row, pixel_column, pixel_row, red_in, green_in,
    // blue_in, zero fill (lowest bit up)
    logic [S_TDATA_W-1:0]  s_tdata;
    // opcode
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // red_out, green_out, blue_out (lowest bit up)
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int pixels_checked;
    int loads_seen;

    // Cells loaded so far; pixel requests only target these
    bit written [DEF_MAX_LATENT_HEIGHT][DEF_MAX_LATENT_WIDTH];
    int tx_gap_max;
    int rx_gap_max;
    bit hold_req;
    int cycle_count;
    int w_eff;
    int h_eff;
    int s_eff;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    latent_preview_upscaler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    latent_preview_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked),
        .loads_seen     (loads_seen)
    );

    function automatic int eff_dim(input int v, input int limit);
        if (v == 0) begin
            return 1;
        end
        return (v > limit) ? limit : v;
    endfunction

    // Offer one beat after a random gap; return at the falling edge after it is taken
    task automatic put_beat(input logic op, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    // Load a cell; the pixel fields carry noise
    task automatic load_cell(input int col, input int row, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        put_beat(OP_LOAD, {4'b0, b, g, r, PIX_W'($urandom), PIX_W'($urandom),
                           CELL_W'(row), CELL_W'(col)});
        written[row][col] = 1'b1;
    endtask

    // Request a pixel; the cell and channel fields carry noise
    task automatic ask_pixel(input int px, input int py);
        put_beat(OP_PIXEL, {4'b0, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            PIX_W'(py), PIX_W'(px), CELL_W'($urandom), CELL_W'($urandom)});
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stalls per beat, one long hold on request
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                gap      = STALL_HOLD;
                hold_req = 1'b0;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles without finishing", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int n;
        int cw;
        int ch;
        int cs;
        int lx;
        int ly;
        int px;
        int py;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_LOAD;
        cfg_we     = 1'b0;
        cfg_idx    = REG_LATENT_WIDTH;
        cfg_wdata  = '0;
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        hold_req   = 1'b0;
        w_eff      = int'(RST_LATENT_WIDTH);
        h_eff      = int'(RST_LATENT_HEIGHT);
        s_eff      = int'(RST_SCALE_FACTOR);
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Tone-map extremes, knot edges and saturation on the reset window
        load_cell(0, 0, 16'h7FFF, 16'h8000, 16'h0000);
        load_cell(63, 63, 16'h0001, 16'hFFFF, 16'h0800);
        load_cell(5, 2, 16'h77FF, 16'h8800, 16'h07FF);
        load_cell(63, 0, 16'h2AAA, 16'hD555, 16'h7FFE);
        load_cell(0, 63, 16'h8001, 16'hFFFE, 16'h0FFF);
        // Outside the current window; read back once the window grows
        load_cell(127, 127, 16'h1000, 16'hF000, 16'h4000);
        ask_pixel(0, 0);
        ask_pixel(7, 7);
        ask_pixel(2047, 2047);
        ask_pixel(47, 16);
        ask_pixel(40, 23);
        ask_pixel(2047, 0);
        ask_pixel(0, 2047);
        ask_pixel(504, 511);
        ask_pixel(512, 0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                drain_results();
                tx_gap_max = GAP_MAX;
                rx_gap_max = GAP_MAX;
                case (ph)
                    1: begin cw = 128; ch = 128; cs = 16; end
                    2: begin
                        cw = 1; ch = 1; cs = 1;
                        tx_gap_max = 0;
                    end
                    3: begin
                        cw = 0; ch = 0; cs = 0;
                        rx_gap_max = 0;
                    end
                    4: begin cw = 255; ch = 129; cs = 31; end
                    5: begin cw = 7; ch = 3; cs = 5; end
                    7: begin cw = 128; ch = 1; cs = 1; end
                    8: begin
                        cw = $urandom_range(1, 128);
                        ch = $urandom_range(1, 128);
                        cs = $urandom_range(1, 16);
                        tx_gap_max = 0;
                        rx_gap_max = 0;
                    end
                    default: begin
                        cw = $urandom_range(1, 128);
                        ch = $urandom_range(1, 128);
                        cs = $urandom_range(1, 16);
                    end
                endcase

                // Write all three registers on consecutive edges
                cfg_we    <= 1'b1;
                cfg_idx   <= REG_LATENT_WIDTH;
                cfg_wdata <= CFG_DATA_W'(cw);
                @(negedge aclk);
                cfg_idx   <= REG_LATENT_HEIGHT;
                cfg_wdata <= CFG_DATA_W'(ch);
                @(negedge aclk);
                cfg_idx   <= REG_SCALE_FACTOR;
                cfg_wdata <= CFG_DATA_W'(cs);
                @(negedge aclk);
                cfg_we    <= 1'b0;
                w_eff = eff_dim(cw, DEF_MAX_LATENT_WIDTH);
                h_eff = eff_dim(ch, DEF_MAX_LATENT_HEIGHT);
                s_eff = eff_dim(cs, DEF_MAX_SCALE);
            end

            // Read back the cell loaded outside the reset window
            if (ph == 1) begin
                ask_pixel(2047, 2047);
            end

            // Stall the result side long enough to back up into the input
            if (ph == STRESS_PHASE) begin
                tx_gap_max = 0;
                hold_req   = 1'b1;
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    // Load anywhere in the store, inside the window or not
                    load_cell($urandom_range(0, 127), $urandom_range(0, 127),
                              CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
                end else begin
                    // Pick a window cell, load it if still empty, then hit it
                    lx = $urandom_range(0, w_eff - 1);
                    ly = $urandom_range(0, h_eff - 1);
                    if (!written[ly][lx]) begin
                        load_cell(lx, ly, CHAN_W'($urandom), CHAN_W'($urandom),
                                  CHAN_W'($urandom));
                    end
                    // The last column and row also take every clamped coordinate
                    px = (lx == w_eff - 1) ? $urandom_range(lx * s_eff, 2047)
                                           : lx * s_eff + $urandom_range(0, s_eff - 1);
                    py = (ly == h_eff - 1) ? $urandom_range(ly * s_eff, 2047)
                                           : ly * s_eff + $urandom_range(0, s_eff - 1);
                    ask_pixel(px, py);
                end
            end
        end

        drain_results();
        $display("Covered %0d latent loads and %0d checked pixels over %0d register settings,",
                 loads_seen, pixels_checked, NUM_PHASES);
        $display("with zero, oversized and single-cell windows, scales 1 to 16 and a long stall.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
